### hdl/qea_qubit_chromosome_store_unit_defines.svh
// Assertion macros for the qubit chromosome store.
`ifndef QEA_QUBIT_CHROMOSOME_STORE_UNIT_DEFINES_SVH
`define QEA_QUBIT_CHROMOSOME_STORE_UNIT_DEFINES_SVH
// Holds cond_b in the cycle after cond_a.
`define QEA_ASSERT_NEXT(label, clk_s, rst_n, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
		else $error(msg);
// Holds cond_b in the same cycle as cond_a.
`define QEA_ASSERT_SAME(label, clk_s, rst_n, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
		else $error(msg);
`endif

### hdl/qea_pkg.sv
// ----------------------------------------------------------------------------
// qea_pkg
// Shared types, op codes and constants of the qubit chromosome store.
// ----------------------------------------------------------------------------
package qea_pkg;
	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ROTATE  = 2'd1,
		OP_OBSERVE = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_ITER,
		ST_SCALE_A,
		ST_SCALE_B,
		ST_DONE
	} state_t;

	// One classified word handed from the front part to the back part.
	typedef struct packed {
		op_t         op;
		logic [11:0] index;
		logic        bad;
		logic        fold;
		logic [15:0] angle;
		logic [15:0] rnd;
	} cmd_t;

	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

	function automatic logic signed [31:0] atan_units(input logic [4:0] i);
		logic signed [31:0] v;
		unique case (i)
			5'd0: v = 32'sd536870912;
			5'd1: v = 32'sd316933406;
			5'd2: v = 32'sd167458907;
			5'd3: v = 32'sd85004756;
			5'd4: v = 32'sd42667331;
			5'd5: v = 32'sd21354465;
			5'd6: v = 32'sd10679838;
			5'd7: v = 32'sd5340245;
			5'd8: v = 32'sd2670163;
			5'd9: v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			5'd20: v = 32'sd652;
			5'd21: v = 32'sd326;
			5'd22: v = 32'sd163;
			5'd23: v = 32'sd81;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction
endpackage

### hdl/qea_front.sv
// ----------------------------------------------------------------------------
// qea_front
// Accepts commands, checks the index bound and queues classified words.
// ----------------------------------------------------------------------------
module qea_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [7:0]        index,
	input  logic signed [15:0] angle,
	input  logic [15:0]       random_value,
	input  logic [8:0]        length_in_use,
	input  logic              pop,
	output logic              cmd_valid,
	output qea_pkg::cmd_t     cmd
);
	localparam int DEPTH = 2;
	qea_pkg::cmd_t fifo_q [DEPTH];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	qea_pkg::cmd_t word;
	logic signed [16:0] ang_fold;

	// Busy blocks starts while a word waits or is popped, so at most one word waits here.
	assign busy = (count_q != 2'd0) || pop;
	assign push = start && !busy;

	always_comb begin
		word = '0;
		word.op = qea_pkg::op_t'(op);
		word.index = 12'(index);
		word.bad = ({1'b0, index} >= length_in_use);
		word.rnd = random_value;
		ang_fold = 17'(angle);
		word.fold = 1'b0;
		if (angle > 16'sd16384) begin
			ang_fold = 17'(angle) - 17'sd32768;
			word.fold = 1'b1;
		end else if (angle < -16'sd16384) begin
			ang_fold = 17'(angle) + 17'sd32768;
			word.fold = 1'b1;
		end
		word.angle = ang_fold[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= word;
	end

	assign cmd_valid = count_q != 2'd0;
	assign cmd = fifo_q[rd_ptr_q];
endmodule

### hdl/qea_back.sv
// ----------------------------------------------------------------------------
// qea_back
// Executes one queued word: table access, square root, CORDIC, scaling and observe.
// ----------------------------------------------------------------------------
module qea_back #(
	parameter int MAX_QUBITS   = 256,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  qea_pkg::cmd_t      cmd,
	output logic               pop,
	output logic               done,
	output logic               status,
	output logic               observed_bit,
	output logic signed [17:0] alpha_out,
	output logic signed [17:0] beta_out
);
	localparam int AW = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
	localparam int NSTEPS = (CORDIC_STEPS < qea_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
		: qea_pkg::ATAN_ENTRIES;

	logic [35:0] mem [MAX_QUBITS];
	logic [35:0] rd_q;

	qea_pkg::state_t state_q, state_d;
	qea_pkg::cmd_t   cmd_q;
	qea_pkg::cmd_t   cmd_in;
	logic [4:0]      it_q;
	logic signed [35:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [32:0]     rem_q;
	logic [16:0]     root_q;
	logic signed [17:0] a_q, b_q;
	logic            bit_q;
	logic            wr_en;
	logic signed [67:0] prod;
	logic signed [67:0] prod_r;
	logic signed [23:0] scaled;
	logic signed [17:0] sat_v;
	logic signed [17:0] cur_a, cur_b;
	logic [34:0]     trial;
	logic            in_range;

	assign in_range = (32'(cmd.index) < 32'(MAX_QUBITS)) && !cmd.bad;
	assign cur_a = rd_q[35:18];
	assign cur_b = rd_q[17:0];

	// An index past the table counts as bad as well.
	always_comb begin
		cmd_in = cmd;
		cmd_in.bad = !in_range;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qea_pkg::ST_IDLE:    if (cmd_valid) state_d = in_range ? qea_pkg::ST_READ
				: qea_pkg::ST_DONE;
			qea_pkg::ST_READ:    state_d = qea_pkg::ST_LOAD;
			qea_pkg::ST_LOAD:    state_d = (cmd_q.op == qea_pkg::OP_INIT ||
				cmd_q.op == qea_pkg::OP_ROTATE) ? qea_pkg::ST_ITER : qea_pkg::ST_DONE;
			qea_pkg::ST_ITER:    if (cmd_q.op == qea_pkg::OP_INIT) begin
					if (it_q == 5'd16) state_d = qea_pkg::ST_DONE;
				end else if (32'(it_q) == NSTEPS - 1) state_d = qea_pkg::ST_SCALE_A;
			qea_pkg::ST_SCALE_A: state_d = qea_pkg::ST_SCALE_B;
			qea_pkg::ST_SCALE_B: state_d = qea_pkg::ST_DONE;
			qea_pkg::ST_DONE:    state_d = qea_pkg::ST_IDLE;
			default:             state_d = qea_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop   = (state_q == qea_pkg::ST_IDLE) && cmd_valid;
		wr_en = (state_q == qea_pkg::ST_DONE) && !cmd_q.bad;
	end

	// Shared scaler: one of x or y goes through the gain multiply per cycle.
	always_comb begin
		prod   = ((state_q == qea_pkg::ST_SCALE_A) ? 68'(x_q) : 68'(y_q)) * 68'(qea_pkg::GAIN_Q30);
		prod_r = prod + (68'sd1 <<< 43);
		scaled = 24'(prod_r >>> 44);
		if (scaled > 24'(qea_pkg::ONE_Q16)) sat_v = qea_pkg::ONE_Q16;
		else if (scaled < -24'(qea_pkg::ONE_Q16)) sat_v = -qea_pkg::ONE_Q16;
		else sat_v = scaled[17:0];
	end

	assign trial = {2'b0, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= qea_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == qea_pkg::ST_IDLE) rd_q <= mem[cmd.index[AW-1:0]];
		if (wr_en) mem[cmd_q.index[AW-1:0]] <= {a_q, b_q};
	end

	always_ff @(posedge clk) begin
		logic [33:0] tb;
		logic [33:0] sub;
		logic signed [35:0] dx, dy;
		unique case (state_q)
			qea_pkg::ST_IDLE: begin
				if (cmd_valid) cmd_q <= cmd_in;
				bit_q <= 1'b0;
				a_q <= '0;
				b_q <= '0;
			end
			qea_pkg::ST_READ: ;
			qea_pkg::ST_LOAD: begin
				a_q <= (cmd_q.op == qea_pkg::OP_INIT) ? 18'(cmd_q.rnd) : cur_a;
				b_q <= cur_b;
				it_q <= 5'd0;
				unique case (cmd_q.op)
					qea_pkg::OP_INIT: begin
						rem_q <= 33'(34'h1_0000_0000 - 34'(cmd_q.rnd) * 34'(cmd_q.rnd));
						root_q <= '0;
					end
					qea_pkg::OP_ROTATE: begin
						x_q <= (cmd_q.fold ? -36'(cur_a) : 36'(cur_a)) <<< 14;
						y_q <= (cmd_q.fold ? -36'(cur_b) : 36'(cur_b)) <<< 14;
						z_q <= 32'($signed(cmd_q.angle)) <<< 16;
					end
					qea_pkg::OP_OBSERVE:
						bit_q <= (36'({cmd_q.rnd, 16'd0}) > 36'(cur_a * cur_a));
					default: ;
				endcase
			end
			qea_pkg::ST_ITER: begin
				it_q <= it_q + 5'd1;
				if (cmd_q.op == qea_pkg::OP_INIT) begin
					// Restoring square root, one result bit per step, bit 16 first.
					tb  = ({17'd0, root_q} << (6'd17 - 6'(it_q))) | (34'd1 << (2 * (5'd16 - it_q)));
					sub = 34'(trial) - tb;
					if (34'(trial) >= tb) begin
						rem_q  <= sub[32:0];
						root_q <= root_q | (17'd1 << (5'd16 - it_q));
					end
					if (it_q == 5'd16) b_q <= 18'((34'(trial) >= tb) ?
						(root_q | 17'd1) : root_q);
				end else begin
					dx = y_q >>> it_q;
					dy = x_q >>> it_q;
					if (!z_q[31]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - qea_pkg::atan_units(it_q);
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + qea_pkg::atan_units(it_q);
					end
				end
			end
			qea_pkg::ST_SCALE_A: a_q <= sat_v;
			qea_pkg::ST_SCALE_B: b_q <= sat_v;
			qea_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= state_q == qea_pkg::ST_DONE;
	end

	always_ff @(posedge clk) begin
		if (state_q == qea_pkg::ST_DONE) begin
			status       <= cmd_q.bad;
			observed_bit <= cmd_q.bad ? 1'b0 : bit_q;
			alpha_out    <= cmd_q.bad ? 18'sd0 : a_q;
			beta_out     <= cmd_q.bad ? 18'sd0 : b_q;
		end
	end
endmodule

### hdl/qea_qubit_chromosome_store_unit.sv
// A word passes read, load, the iterate steps (init and rotate) and scaling (rotate)
// on its way to the done state and strobe; a bad index goes straight to done.
// The back end handles one word at a time; one more word may wait queued.
// Asynchronous active-low reset; length_in_use resets to 256, table is undefined.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// qea_qubit_chromosome_store_unit
// Qubit amplitude table with init, CORDIC rotate and observe operations.
// ----------------------------------------------------------------------------
`include "qea_qubit_chromosome_store_unit_defines.svh"
module qea_qubit_chromosome_store_unit #(
	parameter int MAX_QUBITS   = 256,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [7:0]         index,
	input  logic signed [15:0] angle,
	input  logic [15:0]        random_value,
	output logic               done,
	output logic               status,
	output logic               observed_bit,
	output logic signed [17:0] alpha_out,
	output logic signed [17:0] beta_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         cfg_data
);
	logic [8:0]    length_q;
	logic          pop, cmd_valid;
	qea_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) length_q <= 9'd256;
		else if (cfg_valid && cfg_ready) length_q <= cfg_data;
	end

	qea_front u_front (
		.clk, .arst_n, .start, .busy, .op, .index, .angle, .random_value,
		.length_in_use(length_q), .pop, .cmd_valid, .cmd
	);

	qea_back #(.MAX_QUBITS(MAX_QUBITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .pop, .done, .status, .observed_bit,
		.alpha_out, .beta_out
	);

	`QEA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "busy must follow a start")
	`QEA_ASSERT_SAME(a_pop_valid, clk, arst_n, pop, cmd_valid, "pop from an empty queue")
	`QEA_ASSERT_SAME(a_bad_zero, clk, arst_n, done && status, alpha_out == 18'sd0 && !observed_bit,
		"bad index result not cleared")
endmodule

### verif/qea_qubit_chromosome_store_unit_test.sv
// ----------------------------------------------------------------------------
// qea_qubit_chromosome_store_unit_test
// Drives init, rotate, observe and unused-op words into the qubit store and
// checks every result word against an in-bench amplitude table model.
// ----------------------------------------------------------------------------
module qea_qubit_chromosome_store_unit_test;
	typedef struct packed {
		logic        status;
		logic        obs;
		logic [17:0] alpha;
		logic [17:0] beta;
	} result_t;

	typedef struct {
		qea_pkg::op_t op;
		logic [7:0]  index;
		logic [15:0] angle;
		logic [15:0] rnd;
		logic        has_fixed;
		result_t     fixed;
	} row_t;

	localparam int QUBITS = 256;
	localparam int STEPS = 16;
	localparam int WATCHDOG = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        op = '0;
	logic [7:0]        index = '0;
	logic signed [15:0] angle = '0;
	logic [15:0]       random_value = '0;
	logic              done;
	logic              status;
	logic              observed_bit;
	logic signed [17:0] alpha_out;
	logic signed [17:0] beta_out;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [8:0]        cfg_data = '0;

	longint  amp_alpha[QUBITS];
	longint  amp_beta[QUBITS];
	bit      amp_written[QUBITS];
	int      qubit_count;
	result_t pending_results[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      sender_idle_pct = 0;
	int      words_sent = 0;
	int      words_seen = 0;

	qea_qubit_chromosome_store_unit #(.MAX_QUBITS(QUBITS), .CORDIC_STEPS(STEPS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .index(index),
		.angle(angle), .random_value(random_value), .done(done), .status(status),
		.observed_bit(observed_bit), .alpha_out(alpha_out), .beta_out(beta_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > 65536) return 65536;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic longint apply_gain(longint v);
		return clamp_unit(floor_shift(v * 64'sd652032874 + (64'sd1 <<< 43), 44));
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 32;
		while (b > v && b != 0) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic result_t predict_qubit(qea_pkg::op_t o, logic [7:0] idx,
			logic [15:0] ang_bits, logic [15:0] rnd);
		result_t res;
		longint a, b, x, y, z, dx, dy, ang;
		int steps;
		res = '{1'b0, 1'b0, 18'd0, 18'd0};
		if (idx >= qubit_count) begin
			res.status = 1'b1;
			return res;
		end
		a = amp_alpha[idx];
		b = amp_beta[idx];
		case (o)
		qea_pkg::OP_INIT: begin
			a = rnd;
			b = int_sqrt((64'd1 << 32) - longint'(rnd) * longint'(rnd));
		end
		qea_pkg::OP_ROTATE: begin
			ang = longint'($signed(ang_bits));
			// Angles past a quarter turn are folded back by a half turn with sign flip.
			if (ang > 16384 || ang < -16384) begin
				ang = (ang > 0) ? ang - 32768 : ang + 32768;
				a = -a;
				b = -b;
			end
			x = a * 16384;
			y = b * 16384;
			z = ang * 65536;
			steps = (STEPS < qea_pkg::ATAN_ENTRIES) ? STEPS : qea_pkg::ATAN_ENTRIES;
			for (int i = 0; i < steps; i++) begin
				dx = floor_shift(y, i);
				dy = floor_shift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(qea_pkg::atan_units(5'(i)));
				end else begin
					x += dx; y -= dy; z += longint'(qea_pkg::atan_units(5'(i)));
				end
			end
			a = apply_gain(x);
			b = apply_gain(y);
		end
		qea_pkg::OP_OBSERVE: res.obs = ((longint'(rnd) << 16) > a * a);
		default: ;
		endcase
		amp_alpha[idx] = a;
		amp_beta[idx] = b;
		amp_written[idx] = 1'b1;
		res.alpha = 18'(a);
		res.beta = 18'(b);
		return res;
	endfunction

	// Result words are checked at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			words_seen++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status); errors++;
				end
				if (observed_bit !== want.obs) begin
					$error("observed_bit expected %0d actual %0d", want.obs, observed_bit);
					errors++;
				end
				if (alpha_out !== want.alpha) begin
					$error("alpha_out expected %0d actual %0d", $signed(want.alpha), alpha_out);
					errors++;
				end
				if (beta_out !== want.beta) begin
					$error("beta_out expected %0d actual %0d", $signed(want.beta), beta_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Start stays high after an accept until the next word or an idle cycle replaces it.
	task automatic send_word(qea_pkg::op_t o, logic [7:0] idx, logic [15:0] ang,
			logic [15:0] rnd, logic has_fixed, result_t fixed);
		result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		index <= idx;
		angle <= ang;
		random_value <= rnd;
		@(posedge clk);
		while (busy) @(posedge clk);
		res = predict_qubit(o, idx, ang, rnd);
		if (has_fixed) begin
			if (res != fixed) begin
				$error("table row disagrees with prediction for op %s", o.name());
				errors++;
			end
		end
		pending_results.push_back(res);
		words_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_length(logic [8:0] len);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		qubit_count = len;
	endtask

	function automatic logic [7:0] pick_index();
		int unsigned k;
		k = $urandom_range(19);
		if (k == 0) return 8'($urandom_range(255));
		if (k == 1) return (qubit_count > 0) ? 8'(qubit_count - 1) : 8'd0;
		return 8'($urandom_range((qubit_count > 1) ? qubit_count - 1 : 0));
	endfunction

	task automatic random_phase(int count, int pct);
		logic [7:0] idx;
		qea_pkg::op_t o;
		int unsigned k;
		sender_idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			idx = pick_index();
			k = $urandom_range(9);
			if (idx < qubit_count && !amp_written[idx]) o = qea_pkg::OP_INIT;
			else if (k < 2) o = qea_pkg::OP_INIT;
			else if (k < 6) o = qea_pkg::OP_ROTATE;
			else if (k < 9) o = qea_pkg::OP_OBSERVE;
			else o = qea_pkg::OP_NOP;
			send_word(o, idx, 16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b0,
				'{1'b0, 1'b0, 18'd0, 18'd0});
		end
	endtask

	initial begin
		row_t directed[$];
		result_t none;
		none = '{1'b0, 1'b0, 18'd0, 18'd0};
		qubit_count = 256;
		foreach (amp_written[i]) begin
			amp_written[i] = 1'b0; amp_alpha[i] = 0; amp_beta[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			'{qea_pkg::OP_INIT, 8'd0, 16'd0, 16'd0, 1'b1, '{1'b0, 1'b0, 18'd0, 18'd65536}},
			'{qea_pkg::OP_OBSERVE, 8'd0, 16'd0, 16'hFFFF, 1'b1,
				'{1'b0, 1'b1, 18'd0, 18'd65536}},
			'{qea_pkg::OP_OBSERVE, 8'd0, 16'd0, 16'd0, 1'b1, '{1'b0, 1'b0, 18'd0, 18'd65536}},
			'{qea_pkg::OP_INIT, 8'd255, 16'd0, 16'hFFFF, 1'b0, none},
			'{qea_pkg::OP_OBSERVE, 8'd255, 16'd0, 16'hFFFF, 1'b0, none},
			'{qea_pkg::OP_OBSERVE, 8'd255, 16'd0, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd255, 16'h7FFF, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd255, 16'h8000, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd0, 16'd16384, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd0, 16'hC000, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd0, 16'd16385, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd0, 16'hBFFF, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd0, 16'd0, 16'd0, 1'b0, none},
			'{qea_pkg::OP_INIT, 8'd128, 16'd0, 16'hAAAA, 1'b0, none},
			'{qea_pkg::OP_INIT, 8'd127, 16'd0, 16'h5555, 1'b0, none},
			'{qea_pkg::OP_NOP, 8'd127, 16'h5555, 16'hAAAA, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd128, 16'h5555, 16'd0, 1'b0, none},
			'{qea_pkg::OP_ROTATE, 8'd127, 16'hAAAA, 16'd0, 1'b0, none}
		};
		foreach (directed[i])
			send_word(directed[i].op, directed[i].index, directed[i].angle, directed[i].rnd,
				directed[i].has_fixed, directed[i].fixed);
		drain_results();

		// Shrinking the chromosome turns higher entries into bad indexes.
		write_length(9'd1);
		send_word(qea_pkg::OP_ROTATE, 8'd1, 16'd0, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd0, 18'd0});
		send_word(qea_pkg::OP_OBSERVE, 8'd0, 16'd0, 16'h8000, 1'b0, none);
		drain_results();
		write_length(9'd0);
		send_word(qea_pkg::OP_INIT, 8'd0, 16'd0, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd0, 18'd0});
		drain_results();

		write_length(9'd37);
		random_phase(550, 23);
		drain_results();
		write_length(9'd256);
		random_phase(550, 88);
		drain_results();
		write_length(9'd200);
		random_phase(275, 0);
		drain_results();
		write_length(9'd511);
		random_phase(275, 0);
		drain_results();

		$display("Sent %0d words over lengths 0, 1, 37, 200, 256 and 511; %0d results seen.",
			words_sent, words_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
